@@ hdl/ctts_pkg.sv @@
// Shared types and codes for the cooperative task tick scheduler.
`timescale 1ns / 1ps
package ctts_pkg;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DELETE   = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   localparam logic [2:0] STAT_ADDED      = 3'd0;
   localparam logic [2:0] STAT_FULL       = 3'd1;
   localparam logic [2:0] STAT_DELETED    = 3'd2;
   localparam logic [2:0] STAT_EMPTY      = 3'd3;
   localparam logic [2:0] STAT_TICK_DONE  = 3'd4;
   localparam logic [2:0] STAT_RUN        = 3'd5;
   localparam logic [2:0] STAT_NONE_READY = 3'd6;
   localparam logic [2:0] STAT_BAD_HANDLE = 3'd7;

   localparam logic [1:0] SLOT_ZERO  = 2'd0;
   localparam logic [1:0] SLOT_INDEX = 2'd1;
   localparam logic [1:0] SLOT_FULL  = 2'd2;

   localparam int MAX_RUNS = 8;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] task_handle;
      logic [15:0] first_delay;
      logic [15:0] repeat_period;
      logic [2:0]  slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_out;
      logic [15:0] handle_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       add_write;
      logic       del_clear;
      logic       tick_update;
      logic       disp_update;
      logic       step;
      logic       emit;
      logic       flush;
      logic [2:0] status;
      logic [1:0] slot_sel;
   } ctl_type;

   typedef struct packed {
      logic [1:0] op;
      logic       handle_zero;
      logic       slot_free;
      logic       slot_valid;
      logic       idx_last;
      logic       run_hit;
      logic       run_final;
      logic       held_valid;
   } stat_type;

endpackage

@@ hdl/ctts_datapath.sv @@
// Task tables, slot walker and result register of the scheduler.
`timescale 1ns / 1ps
module ctts_datapath import ctts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_item,
   input  ctl_type  ctl,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_item
);

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [IW-1:0] IDX_LAST = IW'(TASK_SLOTS - 1);
   localparam logic [3:0] FULL_SLOT = 4'(TASK_SLOTS);
   localparam logic [3:0] RUN_FINAL = 4'(MAX_RUNS - 1);

   req_type       req_ff;
   logic [IW-1:0] idx_ff;
   logic          range_ff;
   logic [15:0]   handle_ff    [TASK_SLOTS];
   logic [15:0]   countdown_ff [TASK_SLOTS];
   logic [15:0]   period_ff    [TASK_SLOTS];
   logic [7:0]    pending_ff   [TASK_SLOTS];
   logic          held_valid_ff;
   logic [3:0]    held_slot_ff;
   logic [15:0]   held_handle_ff;
   logic [3:0]    count_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   logic [15:0]   cur_handle;
   logic [15:0]   cur_countdown;
   logic [15:0]   cur_period;
   logic [7:0]    cur_pending;
   logic [7:0]    slot_wide;
   logic          slot_in_range;
   logic [IW-1:0] slot_idx;
   logic [7:0]    idx_wide;
   logic [3:0]    idx_slot;
   logic          run_hit;
   logic [3:0]    sel_slot;

   assign cur_handle    = handle_ff[idx_ff];
   assign cur_countdown = countdown_ff[idx_ff];
   assign cur_period    = period_ff[idx_ff];
   assign cur_pending   = pending_ff[idx_ff];
   assign slot_wide     = 8'(req_item.slot);
   assign slot_in_range = 32'(req_item.slot) < TASK_SLOTS;
   assign slot_idx      = slot_in_range ? slot_wide[IW-1:0] : '0;
   assign idx_wide      = 8'(idx_ff);
   assign idx_slot      = idx_wide[3:0];
   assign run_hit       = (cur_handle != 16'd0) && (cur_pending != 8'd0);

   always_comb begin
      stat.op          = req_ff.cmd;
      stat.handle_zero = req_ff.task_handle == 16'd0;
      stat.slot_free   = cur_handle == 16'd0;
      stat.slot_valid  = range_ff && (cur_handle != 16'd0);
      stat.idx_last    = idx_ff == IDX_LAST;
      stat.run_hit     = run_hit;
      stat.run_final   = run_hit && (count_ff == RUN_FINAL);
      stat.held_valid  = held_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req_item;
         range_ff <= slot_in_range;
         idx_ff   <= (req_item.cmd == OP_DELETE) ? slot_idx : '0;
      end else if (ctl.step) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            handle_ff[i] <= 16'd0;
         end
      end else if (ctl.add_write) begin
         handle_ff[idx_ff] <= req_ff.task_handle;
      end else if (ctl.del_clear) begin
         handle_ff[idx_ff] <= 16'd0;
      end else if (ctl.disp_update && run_hit && (cur_period == 16'd0)) begin
         handle_ff[idx_ff] <= 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add_write) begin
         countdown_ff[idx_ff] <= req_ff.first_delay;
         period_ff[idx_ff]    <= req_ff.repeat_period;
         pending_ff[idx_ff]   <= 8'd0;
      end else if (ctl.tick_update && (cur_handle != 16'd0)) begin
         if (cur_countdown == 16'd0) begin
            if (cur_pending != 8'hFF) begin
               pending_ff[idx_ff] <= cur_pending + 8'd1;
            end
            if (cur_period != 16'd0) begin
               countdown_ff[idx_ff] <= cur_period;
            end
         end else begin
            countdown_ff[idx_ff] <= cur_countdown - 16'd1;
         end
      end else if (ctl.disp_update && run_hit) begin
         pending_ff[idx_ff] <= cur_pending - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         count_ff      <= 4'd0;
      end else if (ctl.load) begin
         held_valid_ff <= 1'b0;
         count_ff      <= 4'd0;
      end else if (ctl.disp_update && run_hit) begin
         held_valid_ff <= 1'b1;
         count_ff      <= count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.disp_update && run_hit) begin
         held_slot_ff   <= idx_slot;
         held_handle_ff <= cur_handle;
      end
   end

   always_comb begin
      case (ctl.slot_sel)
         SLOT_INDEX: sel_slot = idx_slot;
         SLOT_FULL:  sel_slot = FULL_SLOT;
         default:    sel_slot = 4'd0;
      endcase
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (ctl.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = ctl.status;
         rsp_in.slot_out   = sel_slot;
         rsp_in.handle_out = 16'd0;
         rsp_in.last       = 1'b1;
      end else if (ctl.flush) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = STAT_RUN;
         rsp_in.slot_out   = held_slot_ff;
         rsp_in.handle_out = held_handle_ff;
         rsp_in.last       = 1'b1;
      end else if (ctl.disp_update && run_hit && held_valid_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = STAT_RUN;
         rsp_in.slot_out   = held_slot_ff;
         rsp_in.handle_out = held_handle_ff;
         rsp_in.last       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   held_needs_count: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (count_ff != 4'd0))
      else $error("held run without a counted run");

   non_run_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STAT_RUN)) |-> rsp_ff.last)
      else $error("non-run item not marked last");

   run_has_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STAT_RUN)) |-> (rsp_ff.handle_out != 16'd0))
      else $error("run item with empty handle");

endmodule

@@ hdl/ctts_ctrl.sv @@
// Command sequencer of the scheduler.
`timescale 1ns / 1ps
module ctts_ctrl import ctts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output ctl_type  ctl
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_ADD_SCAN  = 3'd2;
   localparam logic [2:0] S_TICK_WALK = 3'd3;
   localparam logic [2:0] S_DISP_WALK = 3'd4;
   localparam logic [2:0] S_FLUSH     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_ADD: begin
                  if (stat.handle_zero) begin
                     ctl.emit   = 1'b1;
                     ctl.status = STAT_BAD_HANDLE;
                     state_in   = S_IDLE;
                  end else begin
                     state_in = S_ADD_SCAN;
                  end
               end
               OP_DELETE: begin
                  ctl.emit = 1'b1;
                  if (stat.slot_valid) begin
                     ctl.del_clear = 1'b1;
                     ctl.status    = STAT_DELETED;
                  end else begin
                     ctl.status = STAT_EMPTY;
                  end
                  state_in = S_IDLE;
               end
               OP_TICK:  state_in = S_TICK_WALK;
               default:  state_in = S_DISP_WALK;
            endcase
         end
         S_ADD_SCAN: begin
            if (stat.slot_free) begin
               ctl.add_write = 1'b1;
               ctl.emit      = 1'b1;
               ctl.status    = STAT_ADDED;
               ctl.slot_sel  = SLOT_INDEX;
               state_in      = S_IDLE;
            end else if (stat.idx_last) begin
               ctl.emit     = 1'b1;
               ctl.status   = STAT_FULL;
               ctl.slot_sel = SLOT_FULL;
               state_in     = S_IDLE;
            end else begin
               ctl.step = 1'b1;
            end
         end
         S_TICK_WALK: begin
            ctl.tick_update = 1'b1;
            if (stat.idx_last) begin
               ctl.emit   = 1'b1;
               ctl.status = STAT_TICK_DONE;
               state_in   = S_IDLE;
            end else begin
               ctl.step = 1'b1;
            end
         end
         S_DISP_WALK: begin
            ctl.disp_update = 1'b1;
            if (stat.run_final || stat.idx_last) begin
               state_in = S_FLUSH;
            end else begin
               ctl.step = 1'b1;
            end
         end
         S_FLUSH: begin
            if (stat.held_valid) begin
               ctl.flush = 1'b1;
            end else begin
               ctl.emit   = 1'b1;
               ctl.status = STAT_NONE_READY;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   flush_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |=> (state_ff == S_IDLE))
      else $error("flush did not end the item");

   idle_touches_nothing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(ctl.add_write || ctl.tick_update || ctl.disp_update))
      else $error("table update while idle");

   load_raises_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> busy)
      else $error("accepted item did not raise busy");

endmodule

@@ hdl/cooperative_task_tick_scheduler.sv @@
// Add: a zero handle is rejected at decode, else the slot scan ends on the first free slot.
// Delete: the result comes from decode. Tick: walks every slot. Dispatch: runs appear during the slot
// walk, and the last result comes from the flush state after the walk. One slot per cycle.
// One item at a time: busy drops in the cycle that carries the last result, and the
// next item can be taken at the edge that ends it; the receiver cannot stall.
// Synchronous reset empties every slot and returns the sequencer to idle.
`timescale 1ns / 1ps
module cooperative_task_tick_scheduler import ctts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   ctl_type  ctl;
   stat_type stat;

   ctts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctl   (ctl)
   );

   ctts_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ tb/sv/cooperative_task_tick_scheduler_tb.sv @@
// Self-checking testbench for the cooperative task tick scheduler slot table.
`timescale 1ns / 1ps
module cooperative_task_tick_scheduler_tb;
   import ctts_pkg::*;

   localparam int SLOTS       = 8;
   localparam int SETTLE      = SLOTS + 8;
   localparam int CYCLE_LIMIT = 200000;

   class task_table_board;
      logic [15:0] handle_tab [SLOTS];
      logic [15:0] count_tab  [SLOTS];
      logic [15:0] period_tab [SLOTS];
      logic [7:0]  runs_tab   [SLOTS];
      rsp_type     due_results [$];
      int          errors;

      function new();
         for (int s = 0; s < SLOTS; s++) begin
            empty_slot(s);
         end
         errors = 0;
      endfunction

      function void empty_slot(int s);
         handle_tab[s] = '0;
         count_tab[s]  = '0;
         period_tab[s] = '0;
         runs_tab[s]   = '0;
      endfunction

      function void owe(logic [2:0] st, int sl, logic [15:0] h, logic lst);
         rsp_type r;
         r.status     = st;
         r.slot_out   = 4'(sl);
         r.handle_out = h;
         r.last       = lst;
         due_results.push_back(r);
      endfunction

      function void take_command(req_type it);
         int s;
         int served;
         rsp_type tail;
         case (it.cmd)
            OP_ADD: begin
               if (it.task_handle == '0) begin
                  owe(STAT_BAD_HANDLE, 0, '0, 1'b1);
               end else begin
                  s = 0;
                  while (s < SLOTS && handle_tab[s] != '0) s++;
                  if (s == SLOTS) begin
                     owe(STAT_FULL, SLOTS, '0, 1'b1);
                  end else begin
                     handle_tab[s] = it.task_handle;
                     count_tab[s]  = it.first_delay;
                     period_tab[s] = it.repeat_period;
                     runs_tab[s]   = '0;
                     owe(STAT_ADDED, s, '0, 1'b1);
                  end
               end
            end
            OP_DELETE: begin
               if (int'(it.slot) >= SLOTS || handle_tab[it.slot] == '0) begin
                  owe(STAT_EMPTY, 0, '0, 1'b1);
               end else begin
                  empty_slot(int'(it.slot));
                  owe(STAT_DELETED, 0, '0, 1'b1);
               end
            end
            OP_TICK: begin
               for (s = 0; s < SLOTS; s++) begin
                  if (handle_tab[s] != '0) begin
                     if (count_tab[s] == '0) begin
                        if (runs_tab[s] != 8'hFF) runs_tab[s] = runs_tab[s] + 8'd1;
                        if (period_tab[s] != '0) count_tab[s] = period_tab[s];
                     end else begin
                        count_tab[s] = count_tab[s] - 16'd1;
                     end
                  end
               end
               owe(STAT_TICK_DONE, 0, '0, 1'b1);
            end
            default: begin
               served = 0;
               for (s = 0; s < SLOTS && served < MAX_RUNS; s++) begin
                  if (handle_tab[s] != '0 && runs_tab[s] != '0) begin
                     owe(STAT_RUN, s, handle_tab[s], 1'b0);
                     served++;
                     runs_tab[s] = runs_tab[s] - 8'd1;
                     if (period_tab[s] == '0) empty_slot(s);
                  end
               end
               if (served == 0) begin
                  owe(STAT_NONE_READY, 0, '0, 1'b1);
               end else begin
                  tail = due_results.pop_back();
                  tail.last = 1'b1;
                  due_results.push_back(tail);
               end
            end
         endcase
      endfunction

      function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual status %0d slot %0d handle %h last %0d",
                     $time, got.status, got.slot_out, got.handle_out, got.last);
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status)
            note_mismatch("status", 16'(want.status), 16'(got.status));
         if (got.slot_out !== want.slot_out)
            note_mismatch("slot_out", 16'(want.slot_out), 16'(got.slot_out));
         if (got.handle_out !== want.handle_out)
            note_mismatch("handle_out", want.handle_out, got.handle_out);
         if (got.last !== want.last)
            note_mismatch("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      cycle_count = 0;

   task_table_board board = new();

   cooperative_task_tick_scheduler #(
      .TASK_SLOTS(SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.take_command(req_item);
         if (rsp_strobe) board.match_result(rsp_item);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type make_cmd(logic [1:0] op, logic [15:0] h, logic [15:0] d,
                                        logic [15:0] p, logic [2:0] sl);
      req_type it;
      it.cmd           = op;
      it.task_handle   = h;
      it.first_delay   = d;
      it.repeat_period = p;
      it.slot          = sl;
      return it;
   endfunction

   task automatic send_command(req_type it);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int n_cycles);
      start    <= 1'b0;
      req_item <= req_type'({$urandom, $urandom});
      repeat (n_cycles) @(posedge clock);
   endtask

   task automatic drain();
      hold_off(1);
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(int n_items, int idle_pct);
      req_type it;
      int pick;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         it = req_type'({$urandom, $urandom});
         if (pick < 90) begin
            it.cmd = (pick < 25) ? OP_ADD : (pick < 40) ? OP_DELETE :
                     (pick < 68) ? OP_TICK : OP_DISPATCH;
            it.task_handle = ($urandom_range(99) < 4) ? 16'd0 : 16'($urandom_range(65535, 1));
            it.first_delay = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            pick = $urandom_range(99);
            it.repeat_period = (pick < 30) ? 16'd0 :
                               (pick < 88) ? 16'($urandom_range(4, 1)) : 16'($urandom);
         end
         while ($urandom_range(99) < idle_pct) hold_off(1);
         send_command(it);
      end
   endtask

   initial begin
      automatic logic [15:0] dir_handle [8] = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                                                16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00};
      automatic logic [15:0] dir_delay  [8] = '{16'd0, 16'd1, 16'd0, 16'hFFFF,
                                                16'd2, 16'd0, 16'd1, 16'd0};
      automatic logic [15:0] dir_period [8] = '{16'd0, 16'd1, 16'hFFFF, 16'd0,
                                                16'd3, 16'd2, 16'd0, 16'd1};
      automatic int sender_idle [4] = '{0, 74, 0, 19};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(make_cmd(OP_ADD, 16'd0, 16'd5, 16'd5, 3'd0));
      send_command(make_cmd(OP_DELETE, 16'd0, 16'd0, 16'd0, 3'd7));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0, 3'd0));
      for (int i = 0; i < 8; i++) begin
         send_command(make_cmd(OP_ADD, dir_handle[i], dir_delay[i], dir_period[i], 3'(i)));
      end
      send_command(make_cmd(OP_ADD, 16'h1234, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DELETE, 16'd0, 16'd0, 16'd0, 3'd7));
      send_command(make_cmd(OP_DELETE, 16'd0, 16'd0, 16'd0, 3'd7));
      send_command(make_cmd(OP_ADD, 16'h1234, 16'd0, 16'd0, 3'd0));
      drain();

      // empty the table, then pile up runs on a delay-zero one-shot and a period-one task
      for (int i = 0; i < SLOTS; i++) begin
         send_command(make_cmd(OP_DELETE, 16'd0, 16'd0, 16'd0, 3'(i)));
      end
      send_command(make_cmd(OP_ADD, 16'hBEEF, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_ADD, 16'h0F0F, 16'd0, 16'd1, 3'd0));
      repeat (6) send_command(make_cmd(OP_TICK, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      send_command(make_cmd(OP_DISPATCH, 16'd0, 16'd0, 16'd0, 3'd0));
      drain();

      foreach (sender_idle[k]) begin
         run_phase(45, sender_idle[k]);
         drain();
      end

      board.errors += board.due_results.size();
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
